[src/trct_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// trct_pkg - shared types and constants of the tunnel relay connection table
// Holds the header codes, result kinds, slot entry layout and the command and
// status groups that join the controller to the datapath.
// ============================================================================
package trct_pkg;

    localparam int TABLE_SLOTS_DEFAULT = 16;

    // Results per input item are capped at this count.
    localparam int RESULT_CAP = 16;
    localparam int CNT_W      = $clog2(RESULT_CAP + 1);

    localparam logic [15:0] ECHO_SOCKET    = 16'h0002;
    localparam logic [31:0] BROADCAST_HOST = 32'hffff_ffff;
    localparam logic [31:0] REGISTER_HOST  = 32'h0000_0000;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd120;

    typedef enum logic [1:0] {
        KIND_FORWARD = 2'd0,
        KIND_ACK     = 2'd1,
        KIND_FULL    = 2'd2
    } t_kind;

    typedef struct packed {
        logic [31:0] host;
        logic [15:0] port;
        logic [31:0] last_active;
    } t_slot_entry;

    typedef struct packed {
        logic accept;   // take the item at the input
        logic issue;    // read the next slot
        logic eval;     // commit the slot under evaluation
        logic finish;   // close the scan, push the final result if any
    } t_dp_cmd;

    typedef struct packed {
        logic in_tick;      // item at the input is a tick
        logic ev_valid;     // a slot is under evaluation
        logic all_issued;   // every slot has been read
        logic ev_need_out;  // the slot under evaluation pushes a result
        logic claim;        // registration claims the slot under evaluation
        logic fin_need_out; // closing the scan pushes a result
        logic out_free;     // output register can take a result now
    } t_dp_status;

endpackage

[src/tunnel_relay_connection_table_core.sv]
`timescale 1ns / 1ps
// ============================================================================
// tunnel_relay_connection_table_core - relay table for tunneled packets
// Registers clients in a slot table and emits one forward result per target
// slot, an ack on registration or a table-full result.
// ============================================================================
// A tick item yields no result. A packet item is accepted, then the scan
// walks the slot memory slot by slot through its single read port, evaluates
// the last slot read, sees the drained read stage and closes; a registration
// stops at the slot it claims. The scan holds while the slot under
// evaluation must push a result and the output register is full and not
// taken. A forward is held back until the next hit or the end of the scan,
// since the last flag is known only then; at most sixteen results leave per
// item.
// Slot host, port and activity time live in memory without reset; only the
// connected bits are cleared, so no clearing pass follows reset. The timeout
// register may be written at any time the block is idle.
// ============================================================================
module tunnel_relay_connection_table_core #(
    parameter int TABLE_SLOTS = trct_pkg::TABLE_SLOTS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: idle timeout in seconds
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [15:0] i_dest_socket,
    input  logic [31:0] i_dest_host,
    input  logic [15:0] i_dest_port,
    input  logic [31:0] i_source_host,
    input  logic [15:0] i_source_port,
    input  logic [31:0] i_arrival_host,
    input  logic [15:0] i_arrival_port,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_slot_index,
    output logic [31:0] o_peer_host,
    output logic [15:0] o_peer_port,
    output logic        o_last
);

    trct_pkg::t_dp_cmd    dp_cmd;
    trct_pkg::t_dp_status dp_status;

    // Sequence accept, scan and close.
    trct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // Hold the table, time base and result registers.
    trct_datapath #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_action       (i_action),
        .i_dest_socket  (i_dest_socket),
        .i_dest_host    (i_dest_host),
        .i_dest_port    (i_dest_port),
        .i_source_host  (i_source_host),
        .i_source_port  (i_source_port),
        .i_arrival_host (i_arrival_host),
        .i_arrival_port (i_arrival_port),
        .i_out_stall    (i_out_stall),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status),
        .o_out_valid    (o_out_valid),
        .o_kind         (o_kind),
        .o_slot_index   (o_slot_index),
        .o_peer_host    (o_peer_host),
        .o_peer_port    (o_peer_port),
        .o_last         (o_last)
    );

endmodule

[src/trct_ctrl.sv]
`timescale 1ns / 1ps
// ============================================================================
// trct_ctrl - sequencer of the relay table
// Accepts items, steps the slot scan and closes it, stalling the scan while
// the output register cannot take a result.
// ============================================================================
module trct_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  trct_pkg::t_dp_status i_status,
    output trct_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   stall_b;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        stall_b = i_status.ev_valid && i_status.ev_need_out && !i_status.out_free;
        case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid && !i_status.in_tick) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.eval  = i_status.ev_valid && !stall_b;
                o_cmd.issue = !i_status.all_issued && !stall_b;
                if (o_cmd.eval && i_status.claim) begin
                    n_state = S_IDLE;
                end else if (!i_status.ev_valid && i_status.all_issued) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!i_status.fin_need_out || i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

[src/trct_datapath.sv]
`timescale 1ns / 1ps
// ============================================================================
// trct_datapath - slot store, scan pipeline and result registers
// Keeps the slot memory and connected bits, the seconds counter and timeout,
// evaluates one slot per cycle while not stalled, holds the pending and output results.
// ============================================================================
module trct_datapath #(
    parameter int TABLE_SLOTS = trct_pkg::TABLE_SLOTS_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [15:0]          i_cfg_wdata,
    input  logic                 i_action,
    input  logic [15:0]          i_dest_socket,
    input  logic [31:0]          i_dest_host,
    input  logic [15:0]          i_dest_port,
    input  logic [31:0]          i_source_host,
    input  logic [15:0]          i_source_port,
    input  logic [31:0]          i_arrival_host,
    input  logic [15:0]          i_arrival_port,
    input  logic                 i_out_stall,
    input  trct_pkg::t_dp_cmd    i_cmd,
    output trct_pkg::t_dp_status o_status,
    output logic                 o_out_valid,
    output logic [1:0]           o_kind,
    output logic [3:0]           o_slot_index,
    output logic [31:0]          o_peer_host,
    output logic [15:0]          o_peer_port,
    output logic                 o_last
);

    localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CW = $clog2(TABLE_SLOTS + 1);

    // configuration and time
    logic [15:0] r_timeout;
    logic [31:0] r_seconds;

    // captured item
    logic        r_reg_mode;
    logic [31:0] r_dest_host;
    logic [15:0] r_dest_port;
    logic [31:0] r_src_host;
    logic [15:0] r_src_port;
    logic [31:0] r_arr_host;
    logic [15:0] r_arr_port;

    // slot store
    trct_pkg::t_slot_entry   r_slot_mem [TABLE_SLOTS];
    trct_pkg::t_slot_entry   r_rd_data;
    logic [TABLE_SLOTS-1:0]  r_conn;

    // scan pipeline
    logic [CW-1:0] r_rd_idx;
    logic          r_ev_valid;
    logic [IW-1:0] r_ev_idx;

    // pending forward, held until the next hit or the end of the scan
    logic                       r_pend_valid;
    logic [3:0]                 r_pend_slot;
    logic [31:0]                r_pend_host;
    logic [15:0]                r_pend_port;
    logic [trct_pkg::CNT_W-1:0] r_cnt;

    // output register
    logic              r_out_valid;
    trct_pkg::t_kind   r_out_kind;
    logic [3:0]        r_out_slot;
    logic [31:0]       r_out_host;
    logic [15:0]       r_out_port;
    logic              r_out_last;
    logic              n_out_valid;
    trct_pkg::t_kind   n_out_kind;
    logic [3:0]        n_out_slot;
    logic [31:0]       n_out_host;
    logic [15:0]       n_out_port;
    logic              n_out_last;

    logic                  start;
    logic                  ev_conn;
    logic [31:0]           idle;
    logic                  reclaim;
    logic                  is_source;
    logic                  hit;
    logic                  hit_ok;
    logic                  claim;
    logic                  refresh;
    logic                  wr_en;
    trct_pkg::t_slot_entry wr_data;
    logic [3:0]            ev_slot4;
    logic                  out_free;

    assign start = i_cmd.accept && !i_action;

    assign ev_conn   = r_conn[r_ev_idx];
    assign idle      = r_seconds - r_rd_data.last_active;
    assign reclaim   = !ev_conn || (idle > {16'd0, r_timeout});
    assign is_source = (r_rd_data.host == r_src_host) && (r_rd_data.port == r_src_port);
    assign hit       = ev_conn && ((r_dest_host == trct_pkg::BROADCAST_HOST) ? !is_source :
                       ((r_rd_data.host == r_dest_host) && (r_rd_data.port == r_dest_port)));
    assign hit_ok    = !r_reg_mode && hit && (r_cnt < trct_pkg::CNT_W'(trct_pkg::RESULT_CAP));
    assign claim     = r_reg_mode && r_ev_valid && reclaim;
    assign refresh   = !r_reg_mode && ev_conn && is_source;
    assign ev_slot4  = 4'(r_ev_idx);
    assign out_free  = !r_out_valid || !i_out_stall;

    assign wr_en = i_cmd.eval && (claim || refresh);
    always_comb begin
        wr_data             = r_rd_data;
        wr_data.last_active = r_seconds;
        if (r_reg_mode) begin
            wr_data.host = r_arr_host;
            wr_data.port = r_arr_port;
        end
    end

    always_comb begin
        o_status              = '0;
        o_status.in_tick      = i_action;
        o_status.ev_valid     = r_ev_valid;
        o_status.all_issued   = (r_rd_idx == CW'(TABLE_SLOTS));
        o_status.ev_need_out  = claim || (hit_ok && r_pend_valid);
        o_status.claim        = claim;
        o_status.fin_need_out = r_reg_mode || r_pend_valid;
        o_status.out_free     = out_free;
    end

    // configuration, time and captured item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= trct_pkg::TIMEOUT_RESET;
            r_seconds <= '0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (i_cmd.accept && i_action) begin
                r_seconds <= r_seconds + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_reg_mode  <= (i_dest_socket == trct_pkg::ECHO_SOCKET) &&
                           (i_dest_host == trct_pkg::REGISTER_HOST);
            r_dest_host <= i_dest_host;
            r_dest_port <= i_dest_port;
            r_src_host  <= i_source_host;
            r_src_port  <= i_source_port;
            r_arr_host  <= i_arrival_host;
            r_arr_port  <= i_arrival_port;
        end
    end

    // slot memory: one read, one write per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd_data <= r_slot_mem[r_rd_idx[IW-1:0]];
        end
        if (wr_en) begin
            r_slot_mem[r_ev_idx] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conn <= '0;
        end else if (i_cmd.eval && claim) begin
            r_conn[r_ev_idx] <= 1'b1;
        end
    end

    // scan pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx   <= '0;
            r_ev_valid <= 1'b0;
        end else if (start) begin
            r_rd_idx   <= '0;
            r_ev_valid <= 1'b0;
        end else if (i_cmd.issue) begin
            r_rd_idx   <= r_rd_idx + CW'(1);
            r_ev_valid <= 1'b1;
        end else if (i_cmd.eval) begin
            r_ev_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_ev_idx <= r_rd_idx[IW-1:0];
        end
    end

    // pending forward and result count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_cnt        <= '0;
        end else if (start || i_cmd.finish) begin
            r_pend_valid <= 1'b0;
            r_cnt        <= '0;
        end else if (i_cmd.eval && hit_ok) begin
            r_pend_valid <= 1'b1;
            r_cnt        <= r_cnt + trct_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval && hit_ok) begin
            r_pend_slot <= ev_slot4;
            r_pend_host <= r_rd_data.host;
            r_pend_port <= r_rd_data.port;
        end
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        n_out_kind  = r_out_kind;
        n_out_slot  = r_out_slot;
        n_out_host  = r_out_host;
        n_out_port  = r_out_port;
        n_out_last  = r_out_last;
        if (i_cmd.eval && claim) begin
            n_out_valid = 1'b1;
            n_out_kind  = trct_pkg::KIND_ACK;
            n_out_slot  = ev_slot4;
            n_out_host  = r_arr_host;
            n_out_port  = r_arr_port;
            n_out_last  = 1'b1;
        end else if ((i_cmd.eval && hit_ok && r_pend_valid) ||
                     (i_cmd.finish && !r_reg_mode && r_pend_valid)) begin
            n_out_valid = 1'b1;
            n_out_kind  = trct_pkg::KIND_FORWARD;
            n_out_slot  = r_pend_slot;
            n_out_host  = r_pend_host;
            n_out_port  = r_pend_port;
            n_out_last  = i_cmd.finish;
        end else if (i_cmd.finish && r_reg_mode) begin
            n_out_valid = 1'b1;
            n_out_kind  = trct_pkg::KIND_FULL;
            n_out_slot  = '0;
            n_out_host  = '0;
            n_out_port  = '0;
            n_out_last  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_kind <= n_out_kind;
        r_out_slot <= n_out_slot;
        r_out_host <= n_out_host;
        r_out_port <= n_out_port;
        r_out_last <= n_out_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_out_kind;
    assign o_slot_index = r_out_slot;
    assign o_peer_host  = r_out_host;
    assign o_peer_port  = r_out_port;
    assign o_last       = r_out_last;

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ============================================================================
// testbench - self-checking bench for the tunnel relay connection table
// Drives registrations, unicast and broadcast packets and seconds ticks into
// the core, mirrors the slot table in a local predictor and compares every
// result field by field against the oldest predicted result.
// ============================================================================
module testbench;

    localparam int SLOTS        = trct_pkg::TABLE_SLOTS_DEFAULT;
    localparam int SETTLE       = 2 * (SLOTS + 3);  // drain time of one packet scan
    localparam int STALL_LIMIT  = 2000;             // cycles without any handshake
    localparam int HOLD_CYCLES  = 150;              // long receiver hold-off
    localparam int POOL         = 10;               // client addresses reused by traffic

    typedef struct packed {
        logic        action;
        logic [15:0] dest_socket;
        logic [31:0] dest_host;
        logic [15:0] dest_port;
        logic [31:0] source_host;
        logic [15:0] source_port;
        logic [31:0] arrival_host;
        logic [15:0] arrival_port;
    } t_relay_item;

    typedef struct packed {
        trct_pkg::t_kind kind;
        logic [3:0]      slot;
        logic [31:0]     host;
        logic [15:0]     port;
        logic            last;
    } t_relay_result;

    // DUT ports
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_action;
    logic [15:0] i_dest_socket;
    logic [31:0] i_dest_host;
    logic [15:0] i_dest_port;
    logic [31:0] i_source_host;
    logic [15:0] i_source_port;
    logic [31:0] i_arrival_host;
    logic [15:0] i_arrival_port;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_kind;
    logic [3:0]  o_slot_index;
    logic [31:0] o_peer_host;
    logic [15:0] o_peer_port;
    logic        o_last;

    // Mirror of the slot table and the seconds counter
    logic        tbl_conn   [SLOTS];
    logic [31:0] tbl_host   [SLOTS];
    logic [15:0] tbl_port   [SLOTS];
    logic [31:0] tbl_active [SLOTS];
    logic [31:0] seconds_now;
    logic [15:0] idle_limit;

    t_relay_result pending_results[$];
    t_relay_result oldest_result;
    int            mismatch_count = 0;
    int            quiet_cycles   = 0;

    // Traffic shaping controls
    logic tx_quiet  = 1'b0;
    logic rx_quiet  = 1'b0;
    logic hold_req  = 1'b0;
    int   hold_left = 0;
    int   rx_burst  = 0;

    logic [31:0] pool_host [POOL];
    logic [15:0] pool_port [POOL];

    tunnel_relay_connection_table_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_dest_socket  (i_dest_socket),
        .i_dest_host    (i_dest_host),
        .i_dest_port    (i_dest_port),
        .i_source_host  (i_source_host),
        .i_source_port  (i_source_port),
        .i_arrival_host (i_arrival_host),
        .i_arrival_port (i_arrival_port),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_slot_index   (o_slot_index),
        .o_peer_host    (o_peer_host),
        .o_peer_port    (o_peer_port),
        .o_last         (o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor: apply one accepted item to the mirror, queue its results
    // ------------------------------------------------------------------------
    function automatic void predict_relay(input t_relay_item it);
        t_relay_result fwd[$];
        t_relay_result r;
        logic [31:0]   idle;
        logic          hit;
        if (it.action) begin
            seconds_now = seconds_now + 32'd1;
            return;
        end
        // Registration: claim the lowest free or expired slot
        if (it.dest_socket == trct_pkg::ECHO_SOCKET &&
            it.dest_host == trct_pkg::REGISTER_HOST) begin
            for (int i = 0; i < SLOTS; i++) begin
                idle = seconds_now - tbl_active[i];
                if (!tbl_conn[i] || idle > 32'(idle_limit)) begin
                    tbl_conn[i]   = 1'b1;
                    tbl_host[i]   = it.arrival_host;
                    tbl_port[i]   = it.arrival_port;
                    tbl_active[i] = seconds_now;
                    r = '{kind: trct_pkg::KIND_ACK, slot: 4'(i), host: it.arrival_host,
                          port: it.arrival_port, last: 1'b1};
                    pending_results.push_back(r);
                    return;
                end
            end
            r = '{kind: trct_pkg::KIND_FULL, slot: 4'd0, host: 32'd0, port: 16'd0,
                  last: 1'b1};
            pending_results.push_back(r);
            return;
        end
        // Refresh every slot that matches the header source
        for (int i = 0; i < SLOTS; i++) begin
            if (tbl_conn[i] && tbl_host[i] == it.source_host && tbl_port[i] == it.source_port)
                tbl_active[i] = seconds_now;
        end
        for (int i = 0; i < SLOTS && fwd.size() < trct_pkg::RESULT_CAP; i++) begin
            if (tbl_conn[i]) begin
                if (it.dest_host == trct_pkg::BROADCAST_HOST)
                    hit = (tbl_host[i] != it.source_host) || (tbl_port[i] != it.source_port);
                else
                    hit = (tbl_host[i] == it.dest_host) && (tbl_port[i] == it.dest_port);
                if (hit) begin
                    r = '{kind: trct_pkg::KIND_FORWARD, slot: 4'(i), host: tbl_host[i],
                          port: tbl_port[i], last: 1'b0};
                    fwd.push_back(r);
                end
            end
        end
        if (fwd.size() > 0)
            fwd[fwd.size() - 1].last = 1'b1;
        foreach (fwd[k])
            pending_results.push_back(fwd[k]);
    endfunction

    // ------------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------------
    function automatic t_relay_item blank_item();
        t_relay_item it;
        it.action       = 1'b0;
        it.dest_socket  = 16'($urandom);
        it.dest_host    = $urandom;
        it.dest_port    = 16'($urandom);
        it.source_host  = $urandom;
        it.source_port  = 16'($urandom);
        it.arrival_host = $urandom;
        it.arrival_port = 16'($urandom);
        return it;
    endfunction

    function automatic t_relay_item tick_item();
        t_relay_item it;
        it = blank_item();
        it.action = 1'b1;
        return it;
    endfunction

    function automatic t_relay_item register_item(input logic [31:0] host,
                                                  input logic [15:0] port);
        t_relay_item it;
        it = blank_item();
        it.dest_socket  = trct_pkg::ECHO_SOCKET;
        it.dest_host    = trct_pkg::REGISTER_HOST;
        it.arrival_host = host;
        it.arrival_port = port;
        return it;
    endfunction

    function automatic t_relay_item packet_item(input logic [15:0] dsock,
                                                input logic [31:0] dhost,
                                                input logic [15:0] dport,
                                                input logic [31:0] shost,
                                                input logic [15:0] sport);
        t_relay_item it;
        it = blank_item();
        it.dest_socket = dsock;
        it.dest_host   = dhost;
        it.dest_port   = dport;
        it.source_host = shost;
        it.source_port = sport;
        return it;
    endfunction

    // Mostly well-formed client traffic over a small address pool, some noise
    function automatic t_relay_item random_relay_item();
        t_relay_item it;
        int          pick;
        int          a;
        int          b;
        it   = blank_item();
        pick = $urandom_range(0, 99);
        a    = $urandom_range(0, POOL - 1);
        b    = $urandom_range(0, POOL - 1);
        if (pick < 22) begin
            it.action = 1'b1;
        end else if (pick < 40) begin
            it = register_item(pool_host[a], pool_port[a]);
        end else if (pick < 65) begin
            it.dest_host   = pool_host[a];
            it.dest_port   = pool_port[a];
            it.source_host = pool_host[b];
            it.source_port = pool_port[b];
        end else if (pick < 85) begin
            it.dest_host   = trct_pkg::BROADCAST_HOST;
            it.source_host = pool_host[a];
            it.source_port = pool_port[a];
        end else if (pick < 92) begin
            // echo socket aimed at a real host is plain traffic
            it.dest_socket = trct_pkg::ECHO_SOCKET;
            it.dest_host   = (pool_host[a] == trct_pkg::REGISTER_HOST) ? 32'd1 : pool_host[a];
            it.dest_port   = pool_port[a];
            it.source_host = pool_host[b];
            it.source_port = pool_port[b];
        end
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Shared driving tasks
    // ------------------------------------------------------------------------
    // Offer one item, hold it until taken, then predict its results.
    // Valid stays high on return; the next call or hold_input_idle decides.
    task automatic send_item(input t_relay_item it);
        int gap;
        @(negedge i_clk);
        if (!tx_quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_action       = it.action;
        i_dest_socket  = it.dest_socket;
        i_dest_host    = it.dest_host;
        i_dest_port    = it.dest_port;
        i_source_host  = it.source_host;
        i_source_port  = it.source_port;
        i_arrival_host = it.arrival_host;
        i_arrival_port = it.arrival_port;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall)
                break;
        end
        predict_relay(it);
    endtask

    task automatic hold_input_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic wait_results_drained();
        while (pending_results.size() > 0)
            @(posedge i_clk);
    endtask

    // Write the timeout only once the block has gone idle
    task automatic set_idle_timeout(input logic [15:0] value);
        hold_input_idle();
        wait_results_drained();
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        idle_limit  = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_basic_relay();
        // register all-ones, all-zero and an ordinary client
        send_item(register_item(32'hffff_ffff, 16'hffff));
        send_item(register_item(32'h0000_0000, 16'h0000));
        send_item(register_item(32'h0a00_0001, 16'h1234));
        // unicast to the zero client, socket all ones
        send_item(packet_item(16'hffff, 32'h0, 16'h0, 32'h0a00_0001, 16'h1234));
        // unicast with no matching slot
        send_item(packet_item(16'h0000, 32'h0a00_0099, 16'h0001, 32'h0a00_0001, 16'h1234));
        // broadcast skips the sender, dest port ignored
        send_item(packet_item(16'h0003, trct_pkg::BROADCAST_HOST, 16'hffff,
                              32'h0a00_0001, 16'h1234));
        // echo socket with a real host relays like any packet
        send_item(packet_item(trct_pkg::ECHO_SOCKET, 32'h0a00_0001, 16'h1234,
                              32'hffff_ffff, 16'hffff));
        send_item(tick_item());
        // same client twice: unicast hits both slots
        send_item(register_item(32'h0a00_0001, 16'h1234));
        send_item(packet_item(16'h5555, 32'h0a00_0001, 16'h1234, 32'h7f00_0001, 16'h0050));
    endtask

    task automatic test_table_full();
        for (int i = 0; i < SLOTS - 4; i++)
            send_item(register_item($urandom, 16'($urandom)));
        send_item(register_item($urandom, 16'($urandom)));
    endtask

    task automatic test_back_pressure();
        // hold the result side while broadcasts to the full table pile up
        rx_quiet = 1'b0;
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++)
            send_item(packet_item(16'($urandom), trct_pkg::BROADCAST_HOST, 16'($urandom),
                                  $urandom, 16'($urandom)));
        // pause the sender until everything has come out
        hold_input_idle();
        wait_results_drained();
        for (int i = 0; i < 4; i++)
            send_item(random_relay_item());
    endtask

    task automatic test_idle_reclaim();
        set_idle_timeout(16'hffff);
        send_item(register_item($urandom, 16'($urandom)));
        set_idle_timeout(16'h0000);
        send_item(tick_item());
        // first: stale slot reclaimed; second: idle equal to timeout is kept
        send_item(register_item($urandom, 16'($urandom)));
        send_item(register_item($urandom, 16'($urandom)));
    endtask

    task automatic test_random_traffic();
        logic [15:0] timeouts [4];
        timeouts = '{16'd3, 16'hffff, 16'd0, trct_pkg::TIMEOUT_RESET};
        foreach (timeouts[p]) begin
            set_idle_timeout(timeouts[p]);
            for (int i = 0; i < 27; i++)
                send_item(random_relay_item());
        end
    endtask

    task automatic test_full_rate();
        set_idle_timeout(16'd5);
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        for (int i = 0; i < 20; i++)
            send_item(random_relay_item());
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts, a long hold-off on request
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            i_out_stall = 1'b1;
            hold_left   = hold_left - 1;
        end else if (rx_quiet) begin
            i_out_stall = 1'b0;
        end else if (rx_burst > 0) begin
            i_out_stall = 1'b1;
            rx_burst    = rx_burst - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_out_stall = 1'b1;
            rx_burst    = $urandom_range(0, 5);
        end else begin
            i_out_stall = 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each taken result with the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: kind %0d slot %0d host %h port %h last %0d",
                       o_kind, o_slot_index, o_peer_host, o_peer_port, o_last);
                mismatch_count++;
            end else begin
                oldest_result = pending_results.pop_front();
                if (o_kind !== oldest_result.kind) begin
                    $error("kind: expected %0d, got %0d", oldest_result.kind, o_kind);
                    mismatch_count++;
                end
                if (o_slot_index !== oldest_result.slot) begin
                    $error("slot_index: expected %0d, got %0d",
                           oldest_result.slot, o_slot_index);
                    mismatch_count++;
                end
                if (o_peer_host !== oldest_result.host) begin
                    $error("peer_host: expected %h, got %h", oldest_result.host, o_peer_host);
                    mismatch_count++;
                end
                if (o_peer_port !== oldest_result.port) begin
                    $error("peer_port: expected %h, got %h", oldest_result.port, o_peer_port);
                    mismatch_count++;
                end
                if (o_last !== oldest_result.last) begin
                    $error("last: expected %0d, got %0d", oldest_result.last, o_last);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run once no handshake has happened for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tunnel_relay_connection_table_core test failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = 16'd0;
        i_in_valid     = 1'b0;
        i_action       = 1'b0;
        i_dest_socket  = 16'd0;
        i_dest_host    = 32'd0;
        i_dest_port    = 16'd0;
        i_source_host  = 32'd0;
        i_source_port  = 16'd0;
        i_arrival_host = 32'd0;
        i_arrival_port = 16'd0;

        for (int i = 0; i < SLOTS; i++) begin
            tbl_conn[i]   = 1'b0;
            tbl_host[i]   = 32'd0;
            tbl_port[i]   = 16'd0;
            tbl_active[i] = 32'd0;
        end
        seconds_now = 32'd0;
        idle_limit  = trct_pkg::TIMEOUT_RESET;

        // client pool with both address extremes in it
        for (int i = 0; i < POOL; i++) begin
            pool_host[i] = $urandom;
            pool_port[i] = 16'($urandom);
        end
        pool_host[0] = 32'hffff_ffff;
        pool_port[0] = 16'hffff;
        pool_host[1] = 32'h0000_0000;
        pool_port[1] = 16'h0000;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_basic_relay();
        test_table_full();
        test_back_pressure();
        test_idle_reclaim();
        test_random_traffic();
        test_full_rate();

        // drain, then give the last scan time to finish
        hold_input_idle();
        wait_results_drained();
        repeat (SETTLE) @(posedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("tunnel_relay_connection_table_core test passed");
        else
            $display("tunnel_relay_connection_table_core test failed");
        $finish;
    end

endmodule
